@@ design/gpu_slab_bump_allocator_unit_assert.svh @@
// assertion macros for the slab allocator, empty when SYNTH is defined
`ifndef GPU_SLAB_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`define GPU_SLAB_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define GSBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GSBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GSBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GSBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/gsba_pkg.sv @@
package gsba_pkg;

    localparam int DEFAULT_MAX_SLABS = 16;

    localparam int CNT_W = 48;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [31:0] RESET_SLAB_BYTES = 32'd268435456;
    localparam logic [4:0] RESET_MIN_ALIGN_LOG2 = 5'd8;
    localparam logic [4:0] RESET_GRANULARITY_LOG2 = 5'd10;

    localparam logic [1:0] CFG_SLAB_BYTES = 2'd0;
    localparam logic [1:0] CFG_MIN_ALIGN_LOG2 = 2'd1;
    localparam logic [1:0] CFG_GRANULARITY_LOG2 = 2'd2;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_TOO_BIG = 2'd1,
        FAULT_NO_SLAB = 2'd2
    } fault_t;

    typedef struct packed {
        logic [31:0] slab_bytes;
        logic [4:0] min_align_log2;
        logic [4:0] granularity_log2;
    } cfg_t;

    typedef struct packed {
        logic [31:0] request_bytes;
        logic [4:0] align_log2;
        logic is_texture;
    } req_t;

    typedef struct packed {
        logic [3:0] slab_index;
        logic [31:0] byte_offset;
        logic opened_slab;
        fault_t fault;
        logic [CNT_W-1:0] used_total;
        logic [CNT_W-1:0] wasted_total;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

@@ design/gsba_alloc.sv @@
module gsba_alloc
    import gsba_pkg::*;
#(
    parameter int MAX_SLABS = DEFAULT_MAX_SLABS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  req_t    req,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int SLAB_W = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;

    logic              have_slab_reg, have_slab_next;
    logic [SLAB_W-1:0] cur_slab_reg, cur_slab_next;
    logic [32:0]       cursor_reg, cursor_next;
    logic              last_buf_reg, last_buf_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  waste_reg, waste_next;

    logic [4:0]        lg_min;
    logic [4:0]        lg_eff;
    logic [33:0]       mask;
    logic [33:0]       cur_ext;
    logic [33:0]       aligned;
    logic              fits;
    logic              too_big;
    logic              last_slab;
    logic              open_new;
    logic              ok;
    fault_t            fault;
    logic [SLAB_W-1:0] slab_sel;
    logic [32:0]       tail;
    logic [33:0]       place_off;
    logic [33:0]       add_waste;
    logic [SLAB_W+3:0] slab_wide;

    always_comb
    begin
        lg_min = (cfg.min_align_log2 > req.align_log2) ? cfg.min_align_log2 : req.align_log2;
        // granularity applies when the kind flips between buffer and texture
        lg_eff = (last_buf_reg == req.is_texture && cfg.granularity_log2 > lg_min)
               ? cfg.granularity_log2 : lg_min;
        mask = (34'd1 << lg_eff) - 34'd1;
        cur_ext = {1'b0, cursor_reg};
        aligned = (cur_ext + mask) & ~mask;
        fits = ({1'b0, aligned} + 35'(req.request_bytes)) <= 35'(cfg.slab_bytes);
        too_big = req.request_bytes >= cfg.slab_bytes;
        last_slab = ((SLAB_W+1)'(cur_slab_reg) + (SLAB_W+1)'(1)) >= (SLAB_W+1)'(MAX_SLABS);
        open_new = !have_slab_reg || !fits;
        if (too_big)
        begin
            fault = FAULT_TOO_BIG;
        end
        else if (have_slab_reg && !fits && last_slab)
        begin
            fault = FAULT_NO_SLAB;
        end
        else
        begin
            fault = FAULT_NONE;
        end
        ok = (fault == FAULT_NONE);
        slab_sel = have_slab_reg ? (cur_slab_reg + SLAB_W'(1)) : '0;
        tail = (have_slab_reg && {1'b0, cfg.slab_bytes} > cursor_reg)
             ? ({1'b0, cfg.slab_bytes} - cursor_reg) : '0;
        place_off = open_new ? '0 : aligned;
        // a new slab wastes the old tail, an existing one wastes the padding
        add_waste = open_new ? {1'b0, tail} : (aligned - cur_ext);
    end

    always_comb
    begin
        have_slab_next = have_slab_reg;
        cur_slab_next = cur_slab_reg;
        cursor_next = cursor_reg;
        last_buf_next = last_buf_reg;
        used_next = used_reg;
        waste_next = waste_reg;
        if (fire && ok)
        begin
            have_slab_next = 1'b1;
            cur_slab_next = open_new ? slab_sel : cur_slab_reg;
            cursor_next = 33'(place_off + 34'(req.request_bytes));
            last_buf_next = !req.is_texture;
            used_next = sat_add(used_reg, CNT_W'(req.request_bytes));
            waste_next = sat_add(waste_reg, CNT_W'(add_waste));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_slab_reg <= 1'b0;
            cur_slab_reg <= '0;
            cursor_reg <= '0;
            last_buf_reg <= 1'b0;
            used_reg <= '0;
            waste_reg <= '0;
        end
        else
        begin
            have_slab_reg <= have_slab_next;
            cur_slab_reg <= cur_slab_next;
            cursor_reg <= cursor_next;
            last_buf_reg <= last_buf_next;
            used_reg <= used_next;
            waste_reg <= waste_next;
        end
    end

    always_comb
    begin
        slab_wide = (SLAB_W+4)'(cur_slab_next);
        res.slab_index = ok ? slab_wide[3:0] : 4'd0;
        res.byte_offset = ok ? place_off[31:0] : 32'd0;
        res.opened_slab = ok && open_new;
        res.fault = fault;
        res.used_total = used_next;
        res.wasted_total = waste_next;
    end

endmodule

@@ design/gpu_slab_bump_allocator_unit.sv @@
// the accepted item is held in the input register, then placed into the result register
// throughput: one item per cycle while out_stall is low, set by the placement and cursor update loop
// the input register refills while a finished result waits on out_stall
// reset: asynchronous active low; no slab open, cursor and totals zero, config at defaults
// config writes are always ready and take effect for the next item placed
module gpu_slab_bump_allocator_unit
    import gsba_pkg::*;
#(
    parameter int MAX_SLABS = DEFAULT_MAX_SLABS
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] request_bytes,
    input  logic [4:0]  align_log2,
    input  logic        is_texture,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  slab_index,
    output logic [31:0] byte_offset,
    output logic        opened_slab,
    output logic [1:0]  fault,
    output logic [47:0] used_total,
    output logic [47:0] wasted_total,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "gpu_slab_bump_allocator_unit_assert.svh"

    cfg_t    cfg_reg;
    logic    in_valid_reg, in_valid_next;
    req_t    req_reg;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;
    result_t res;
    logic    advance;
    logic    in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slab_bytes <= RESET_SLAB_BYTES;
            cfg_reg.min_align_log2 <= RESET_MIN_ALIGN_LOG2;
            cfg_reg.granularity_log2 <= RESET_GRANULARITY_LOG2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SLAB_BYTES:       cfg_reg.slab_bytes <= cfg_data;
                CFG_MIN_ALIGN_LOG2:   cfg_reg.min_align_log2 <= cfg_data[4:0];
                CFG_GRANULARITY_LOG2: cfg_reg.granularity_log2 <= cfg_data[4:0];
                default:              ;
            endcase
        end
    end

    // the held item moves on whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.request_bytes <= request_bytes;
            req_reg.align_log2 <= align_log2;
            req_reg.is_texture <= is_texture;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    gsba_alloc #(
        .MAX_SLABS (MAX_SLABS)
    ) u_alloc (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (req_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    assign out_valid = out_valid_reg;
    assign slab_index = res_reg.slab_index;
    assign byte_offset = res_reg.byte_offset;
    assign opened_slab = res_reg.opened_slab;
    assign fault = res_reg.fault;
    assign used_total = res_reg.used_total;
    assign wasted_total = res_reg.wasted_total;

    `GSBA_ASSERT_IMP(a_fault_clears_place, clk, rst_n,
        out_valid_reg && res_reg.fault != FAULT_NONE,
        res_reg.slab_index == 4'd0 && res_reg.byte_offset == 32'd0 && !res_reg.opened_slab,
        "faulted item carries a placement")
    `GSBA_ASSERT_IMP(a_open_at_zero, clk, rst_n,
        out_valid_reg && res_reg.opened_slab,
        res_reg.byte_offset == 32'd0 && res_reg.fault == FAULT_NONE,
        "new slab item not at offset zero")
    `GSBA_ASSERT_NEXT(a_held_item_kept, clk, rst_n,
        in_valid_reg && !advance, in_valid_reg, "held item dropped")
    `GSBA_ASSERT_NEXT(a_drained_result, clk, rst_n,
        out_valid_reg && !out_stall && !advance, !out_valid_reg, "taken result repeated")

endmodule

@@ bench/testbench.sv @@
module testbench
    import gsba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLABS = DEFAULT_MAX_SLABS;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] request_bytes;
    logic [4:0]  align_log2;
    logic        is_texture;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  slab_index;
    logic [31:0] byte_offset;
    logic        opened_slab;
    logic [1:0]  fault;
    logic [47:0] used_total;
    logic [47:0] wasted_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // allocator state as the bench tracks it
    logic [31:0] slab_cap;
    logic [4:0]  min_lg;
    logic [4:0]  gran_lg;
    logic        slab_open;
    int          open_slab;
    logic [32:0] bump_ptr;
    logic        prev_was_buffer;
    logic [47:0] used_bytes;
    logic [47:0] wasted_bytes;

    result_t pending_placements[$];
    int      error_count;
    int      result_count;
    int      quiet_cycles;
    bit      idling_on;
    bit      hold_off_pending;

    gpu_slab_bump_allocator_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .request_bytes(request_bytes),
        .align_log2   (align_log2),
        .is_texture   (is_texture),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slab_index   (slab_index),
        .byte_offset  (byte_offset),
        .opened_slab  (opened_slab),
        .fault        (fault),
        .used_total   (used_total),
        .wasted_total (wasted_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {17'd0, a} + {1'b0, b};
        return (s > 65'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function automatic logic [63:0] round_up(input logic [63:0] v, input logic [4:0] lg);
        logic [63:0] m;
        m = (64'd1 << lg) - 64'd1;
        return (v + m) & ~m;
    endfunction

    // places one request and, unless it faults, advances the tracked state
    function automatic result_t place_request(input logic [31:0] size, input logic [4:0] req_lg,
                                              input logic tex);
        result_t     r;
        logic [4:0]  lg;
        logic [63:0] cap;
        logic [63:0] aligned;
        logic [63:0] base_off;
        logic        open_new;
        int          next_slab;
        r = '0;
        r.fault = FAULT_NONE;
        r.used_total = used_bytes;
        r.wasted_total = wasted_bytes;
        cap = {32'd0, slab_cap};
        if ({32'd0, size} >= cap)
        begin
            r.fault = FAULT_TOO_BIG;
            return r;
        end
        lg = req_lg;
        if (min_lg > lg)
            lg = min_lg;
        // granularity kicks in when the kind flips
        if (prev_was_buffer == tex && gran_lg > lg)
            lg = gran_lg;
        open_new = 1'b0;
        next_slab = open_slab;
        aligned = 64'd0;
        if (!slab_open)
        begin
            open_new = 1'b1;
            next_slab = 0;
        end
        else
        begin
            aligned = round_up({31'd0, bump_ptr}, lg);
            if (aligned > cap || cap - aligned < {32'd0, size})
            begin
                if (open_slab + 1 >= MAX_SLABS)
                begin
                    r.fault = FAULT_NO_SLAB;
                    return r;
                end
                open_new = 1'b1;
                next_slab = open_slab + 1;
            end
        end
        if (open_new)
        begin
            // abandoned tail, none if the slab shrank under the cursor
            if (slab_open && cap > {31'd0, bump_ptr})
                wasted_bytes = add_sat48(wasted_bytes, cap - {31'd0, bump_ptr});
            slab_open = 1'b1;
            open_slab = next_slab;
            aligned = 64'd0;
            base_off = 64'd0;
        end
        else
        begin
            aligned = round_up({31'd0, bump_ptr}, lg);
            base_off = {31'd0, bump_ptr};
        end
        used_bytes = add_sat48(used_bytes, {32'd0, size});
        wasted_bytes = add_sat48(wasted_bytes, aligned - base_off);
        bump_ptr = aligned[32:0] + {1'b0, size};
        prev_was_buffer = !tex;
        r.slab_index = 4'(open_slab);
        r.byte_offset = aligned[31:0];
        r.opened_slab = open_new;
        r.used_total = used_bytes;
        r.wasted_total = wasted_bytes;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_placements.size() == 0)
                report_mismatch("result with no request waiting");
            else
            begin
                want = pending_placements.pop_front();
                if (slab_index !== want.slab_index)
                    report_mismatch($sformatf("slab_index got %0d want %0d",
                                              slab_index, want.slab_index));
                if (byte_offset !== want.byte_offset)
                    report_mismatch($sformatf("byte_offset got 0x%0h want 0x%0h",
                                              byte_offset, want.byte_offset));
                if (opened_slab !== want.opened_slab)
                    report_mismatch($sformatf("opened_slab got %0d want %0d",
                                              opened_slab, want.opened_slab));
                if (fault !== want.fault)
                    report_mismatch($sformatf("fault got %0d want %0d", fault, want.fault));
                if (used_total !== want.used_total)
                    report_mismatch($sformatf("used_total got 0x%0h want 0x%0h",
                                              used_total, want.used_total));
                if (wasted_total !== want.wasted_total)
                    report_mismatch($sformatf("wasted_total got 0x%0h want 0x%0h",
                                              wasted_total, want.wasted_total));
            end
            result_count++;
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver side stalls
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_pending = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic [31:0] size, input logic [4:0] lg, input logic tex);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        request_bytes <= size;
        align_log2 <= lg;
        is_texture <= tex;
        do
            @(posedge clk);
        while (in_stall);
        pending_placements.push_back(place_request(size, lg, tex));
    endtask

    task automatic wait_all_placed();
        in_valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // leaves cfg_valid high, the caller drops it after the last write
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SLAB_BYTES:       slab_cap = value;
            CFG_MIN_ALIGN_LOG2:   min_lg = value[4:0];
            CFG_GRANULARITY_LOG2: gran_lg = value[4:0];
            default: ;
        endcase
    endtask

    task automatic set_allocator(input logic [31:0] bytes, input logic [4:0] min_a,
                                 input logic [4:0] gran);
        wait_all_placed();
        write_register(CFG_SLAB_BYTES, bytes);
        write_register(CFG_MIN_ALIGN_LOG2, {27'd0, min_a});
        write_register(CFG_GRANULARITY_LOG2, {27'd0, gran});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return $urandom_range(0, 255);
        else if (roll < 78)
            return $urandom_range(0, 65535);
        else if (roll < 93)
            return $urandom & 32'h00FF_FFFF;
        else if (roll < 97)
            return slab_cap - $urandom_range(0, 2);
        else
            return $urandom;
    endfunction

    function automatic logic [4:0] pick_align();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return $urandom_range(0, 6);
        else if (roll < 9)
            return $urandom_range(0, 12);
        else
            return $urandom_range(0, 31);
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(pick_size(), pick_align(), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_first_and_oversize();
        send_request(32'd100, 5'd0, 1'b0);          // opens slab 0
        send_request(32'hFFFF_FFFF, 5'd31, 1'b1);   // too big
        send_request(32'd268435456, 5'd0, 1'b0);    // exactly slab size
        send_request(32'd0, 5'd0, 1'b1);            // kind switch, granularity
        send_request(32'd5, 5'd31, 1'b0);           // alignment past the slab end
        send_request(32'd268435455, 5'd0, 1'b0);    // one byte short of a fresh slab
        send_request(32'd0, 5'd0, 1'b0);            // zero bytes at the very end
        send_request(32'd1, 5'd5, 1'b1);            // no room, nothing to waste
    endtask

    task automatic test_alignment_extremes();
        set_allocator(32'h1000_0000, 5'd0, 5'd0);
        send_request(32'd3, 5'd0, 1'b0);
        send_request(32'd7, 5'd1, 1'b1);
        send_request(32'd9, 5'd0, 1'b1);
        set_allocator(32'h1000_0000, 5'd31, 5'd31);
        send_request(32'd1, 5'd0, 1'b0);
        send_request(32'd1, 5'd31, 1'b1);
    endtask

    task automatic test_tiny_and_huge_slab();
        // shrinking onto the cursor of an open slab leaves its tail empty
        set_allocator(32'd1, 5'd0, 5'd0);
        send_request(32'd0, 5'd0, 1'b0);
        send_request(32'd1, 5'd0, 1'b1);
        set_allocator(32'hFFFF_FFFF, 5'd0, 5'd0);
        send_request(32'hFFFF_FFFE, 5'd0, 1'b0);
        send_request(32'hFFFF_FFFF, 5'd0, 1'b0);
    endtask

    task automatic test_random_default();
        set_allocator(RESET_SLAB_BYTES, RESET_MIN_ALIGN_LOG2, RESET_GRANULARITY_LOG2);
        run_random(250);
    endtask

    task automatic test_backpressure();
        wait_all_placed();
        idling_on = 1'b0;
        hold_off_pending = 1'b1;
        run_random(30);
        // sender waits for every result before going on
        wait_all_placed();
        idling_on = 1'b1;
    endtask

    task automatic test_random_small_slabs();
        set_allocator(32'd65536, 5'($urandom_range(0, 4)), 5'($urandom_range(4, 9)));
        run_random(150);
    endtask

    task automatic test_slab_exhaustion();
        set_allocator(32'd16, 5'd0, 5'd0);
        for (int i = 0; i < 18; i++)
            send_request(32'd15, 5'd0, 1'(i));
    endtask

    task automatic test_random_huge_slab();
        set_allocator(32'hFFFF_FFFF, 5'd0, 5'd12);
        run_random(270);
    endtask

    task automatic test_random_coarse_align();
        set_allocator(32'hFFFF_FFFF, 5'd31, 5'd0);
        run_random(20);
        set_allocator(32'hFFFF_FFFF, 5'd0, 5'd31);
        run_random(20);
    endtask

    task automatic test_random_no_idle();
        set_allocator(32'hFFFF_FFFF, 5'd4, 5'd6);
        idling_on = 1'b0;
        run_random(100);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        request_bytes <= '0;
        align_log2 <= '0;
        is_texture <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SLAB_BYTES;
        cfg_data <= '0;
        slab_cap = RESET_SLAB_BYTES;
        min_lg = RESET_MIN_ALIGN_LOG2;
        gran_lg = RESET_GRANULARITY_LOG2;
        slab_open = 1'b0;
        open_slab = 0;
        bump_ptr = '0;
        prev_was_buffer = 1'b0;
        used_bytes = '0;
        wasted_bytes = '0;
        error_count = 0;
        result_count = 0;
        quiet_cycles = 0;
        idling_on = 1'b1;
        hold_off_pending = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_and_oversize();
        test_alignment_extremes();
        test_tiny_and_huge_slab();
        test_random_default();
        test_backpressure();
        test_random_small_slabs();
        test_slab_exhaustion();
        test_random_huge_slab();
        test_random_coarse_align();
        test_random_no_idle();

        wait_all_placed();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ gpu_slab_bump_allocator_unit.f @@
+incdir+design
design/gsba_pkg.sv
design/gsba_alloc.sv
design/gpu_slab_bump_allocator_unit.sv
bench/testbench.sv
